// ===== hdl/sdtq_pkg.sv =====
package sdtq_pkg;

    localparam int DEPTH_DEFAULT     = 16;
    localparam int TIME_BITS_DEFAULT = 32;
    localparam int NUM_HANDLES       = 16;
    localparam int HANDLE_BITS       = 4;

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_ADJUST = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_TICK   = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_QUEUED     = 2'd1,
        STATUS_NOT_QUEUED = 2'd2
    } status_t;

    typedef struct packed {
        req_type_t               req_type;
        logic [HANDLE_BITS-1:0]  handle;
        logic [31:0]             deadline;
        logic [31:0]             now_time;
    } sdtq_req_t;

    typedef struct packed {
        status_t                 status;
        logic [HANDLE_BITS-1:0]  expired_handle;
        logic                    expired_valid;
        logic                    last;
    } sdtq_rsp_t;

    // Operation broadcast to every cell of the chain at once.
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2,
        CELL_SHIFT  = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t                op;
        logic [HANDLE_BITS-1:0]  handle;
    } cell_ctrl_t;

endpackage

// ===== hdl/sdtq_cell.sv =====
module sdtq_cell #(
    parameter int TIME_BITS = sdtq_pkg::TIME_BITS_DEFAULT
) (
    input  logic                              clk,
    input  sdtq_pkg::cell_ctrl_t              ctrl,
    input  logic [TIME_BITS-1:0]              ins_expiry,
    input  logic                              occupied,
    input  logic                              left_keep,
    input  logic [sdtq_pkg::HANDLE_BITS-1:0]  left_handle,
    input  logic [TIME_BITS-1:0]              left_expiry,
    input  logic [sdtq_pkg::HANDLE_BITS-1:0]  right_handle,
    input  logic [TIME_BITS-1:0]              right_expiry,
    input  logic                              seen_in,
    output logic                              keep,
    output logic                              seen_out,
    output logic [sdtq_pkg::HANDLE_BITS-1:0]  slot_handle,
    output logic [TIME_BITS-1:0]              slot_expiry
);

    logic [sdtq_pkg::HANDLE_BITS-1:0] handle_reg;
    logic [sdtq_pkg::HANDLE_BITS-1:0] handle_next;
    logic [TIME_BITS-1:0]             expiry_reg;
    logic [TIME_BITS-1:0]             expiry_next;

    // An occupied cell stays put on insert when it expires no later than the new timer,
    // so equal deadlines keep arrival order.
    assign keep     = occupied && (expiry_reg <= ins_expiry);
    assign seen_out = seen_in || (occupied && (handle_reg == ctrl.handle));

    assign slot_handle = handle_reg;
    assign slot_expiry = expiry_reg;

    always_comb
    begin
        handle_next = handle_reg;
        expiry_next = expiry_reg;
        case (ctrl.op)
            sdtq_pkg::CELL_INSERT:
            begin
                if (!keep)
                begin
                    if (left_keep)
                    begin
                        handle_next = ctrl.handle;
                        expiry_next = ins_expiry;
                    end
                    else
                    begin
                        handle_next = left_handle;
                        expiry_next = left_expiry;
                    end
                end
            end
            sdtq_pkg::CELL_REMOVE:
            begin
                // Every cell at or after the matching one pulls from the right.
                if (seen_out)
                begin
                    handle_next = right_handle;
                    expiry_next = right_expiry;
                end
            end
            sdtq_pkg::CELL_SHIFT:
            begin
                handle_next = right_handle;
                expiry_next = right_expiry;
            end
            default:
            begin
                handle_next = handle_reg;
                expiry_next = expiry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        handle_reg <= handle_next;
        expiry_reg <= expiry_next;
    end

endmodule

// ===== hdl/sorted_deadline_timer_queue_unit.sv =====
// Sorted timer queue: up to DEPTH timers (at most 16 handles) held in a chain
// of cells in ascending expiry order, equal expiries in arrival order. Add and
// delete each act once on the chain and give one result beat; adjust removes
// the timer and then puts it back with a sorted insert. Tick first captures the
// time and then pops one due timer per cycle from the head of the chain while
// the result side does not stall, one result beat each, or gives one beat
// without a timer when none is due. A new request is taken once the previous
// request has finished and the result register is free or being drained.
module sorted_deadline_timer_queue_unit #(
    parameter int DEPTH     = sdtq_pkg::DEPTH_DEFAULT,
    parameter int TIME_BITS = sdtq_pkg::TIME_BITS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  sdtq_pkg::sdtq_req_t req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output sdtq_pkg::sdtq_rsp_t rsp
);

    localparam int CAPACITY = (DEPTH < sdtq_pkg::NUM_HANDLES) ? DEPTH
                                                              : sdtq_pkg::NUM_HANDLES;
    localparam int CW       = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_INSERT,
        S_POP
    } state_t;

    state_t                               state_reg, state_next;
    logic [CW-1:0]                        count_reg, count_next;
    logic [sdtq_pkg::NUM_HANDLES-1:0]     queued_reg, queued_next;
    logic                                 rsp_valid_reg, rsp_valid_next;
    sdtq_pkg::sdtq_rsp_t                  rsp_reg, rsp_next;
    logic [sdtq_pkg::HANDLE_BITS-1:0]     pend_handle_reg, pend_handle_next;
    logic [TIME_BITS-1:0]                 pend_time_reg, pend_time_next;

    sdtq_pkg::cell_ctrl_t                 ctrl;
    logic [TIME_BITS-1:0]                 ins_expiry;

    logic [DEPTH-1:0]                     occ;
    logic [DEPTH-1:0]                     keep;
    logic [DEPTH-1:0]                     seen;
    logic [sdtq_pkg::HANDLE_BITS-1:0]     c_handle [DEPTH];
    logic [TIME_BITS-1:0]                 c_expiry [DEPTH];

    logic                                 out_free;
    logic                                 accept;
    logic                                 hit;
    logic                                 head_due;
    logic                                 second_due;
    logic [TIME_BITS-1:0]                 req_deadline;

    assign out_free     = !rsp_valid_reg || rsp_ready;
    assign req_ready    = (state_reg == S_IDLE) && out_free;
    assign accept       = req_valid && req_ready;
    assign hit          = queued_reg[req.handle];
    assign req_deadline = TIME_BITS'(req.deadline);
    assign head_due     = occ[0] && (c_expiry[0] <= pend_time_reg);
    assign second_due   = occ[1] && (c_expiry[1] <= pend_time_reg);

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                             left_keep;
        logic [sdtq_pkg::HANDLE_BITS-1:0] left_handle;
        logic [TIME_BITS-1:0]             left_expiry;
        logic [sdtq_pkg::HANDLE_BITS-1:0] right_handle;
        logic [TIME_BITS-1:0]             right_expiry;
        logic                             seen_in;

        assign occ[i] = CW'(i) < count_reg;

        if (i == 0)
        begin : g_head
            assign left_keep   = 1'b1;
            assign left_handle = ctrl.handle;
            assign left_expiry = ins_expiry;
            assign seen_in     = 1'b0;
        end
        else
        begin : g_body
            assign left_keep   = keep[i-1];
            assign left_handle = c_handle[i-1];
            assign left_expiry = c_expiry[i-1];
            assign seen_in     = seen[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_handle = c_handle[i];
            assign right_expiry = c_expiry[i];
        end
        else
        begin : g_inner
            assign right_handle = c_handle[i+1];
            assign right_expiry = c_expiry[i+1];
        end

        sdtq_cell #(
            .TIME_BITS (TIME_BITS)
        ) u_cell (
            .clk          (clk),
            .ctrl         (ctrl),
            .ins_expiry   (ins_expiry),
            .occupied     (occ[i]),
            .left_keep    (left_keep),
            .left_handle  (left_handle),
            .left_expiry  (left_expiry),
            .right_handle (right_handle),
            .right_expiry (right_expiry),
            .seen_in      (seen_in),
            .keep         (keep[i]),
            .seen_out     (seen[i]),
            .slot_handle  (c_handle[i]),
            .slot_expiry  (c_expiry[i])
        );
    end

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        queued_next      = queued_reg;
        rsp_valid_next   = rsp_valid_reg;
        rsp_next         = rsp_reg;
        pend_handle_next = pend_handle_reg;
        pend_time_next   = pend_time_reg;
        ctrl.op          = sdtq_pkg::CELL_HOLD;
        ctrl.handle      = pend_handle_reg;
        ins_expiry       = pend_time_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rsp_next.status         = sdtq_pkg::STATUS_OK;
                    rsp_next.expired_handle = '0;
                    rsp_next.expired_valid  = 1'b0;
                    rsp_next.last           = 1'b1;
                    case (req.req_type)
                        sdtq_pkg::REQ_ADD:
                        begin
                            rsp_valid_next = 1'b1;
                            if (hit || (count_reg >= CW'(CAPACITY)))
                            begin
                                rsp_next.status = sdtq_pkg::STATUS_QUEUED;
                            end
                            else
                            begin
                                ctrl.op                 = sdtq_pkg::CELL_INSERT;
                                ctrl.handle             = req.handle;
                                ins_expiry              = req_deadline;
                                count_next              = count_reg + CW'(1);
                                queued_next[req.handle] = 1'b1;
                            end
                        end
                        sdtq_pkg::REQ_ADJUST:
                        begin
                            rsp_valid_next = 1'b1;
                            if (!hit)
                            begin
                                rsp_next.status = sdtq_pkg::STATUS_NOT_QUEUED;
                            end
                            else
                            begin
                                // Take the timer out now, put it back sorted next cycle.
                                ctrl.op          = sdtq_pkg::CELL_REMOVE;
                                ctrl.handle      = req.handle;
                                count_next       = count_reg - CW'(1);
                                pend_handle_next = req.handle;
                                pend_time_next   = req_deadline;
                                state_next       = S_INSERT;
                            end
                        end
                        sdtq_pkg::REQ_DELETE:
                        begin
                            rsp_valid_next = 1'b1;
                            if (!hit)
                            begin
                                rsp_next.status = sdtq_pkg::STATUS_NOT_QUEUED;
                            end
                            else
                            begin
                                ctrl.op                 = sdtq_pkg::CELL_REMOVE;
                                ctrl.handle             = req.handle;
                                count_next              = count_reg - CW'(1);
                                queued_next[req.handle] = 1'b0;
                            end
                        end
                        sdtq_pkg::REQ_TICK:
                        begin
                            pend_time_next = TIME_BITS'(req.now_time);
                            state_next     = S_POP;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_INSERT:
            begin
                ctrl.op     = sdtq_pkg::CELL_INSERT;
                ctrl.handle = pend_handle_reg;
                ins_expiry  = pend_time_reg;
                count_next  = count_reg + CW'(1);
                state_next  = S_IDLE;
            end
            S_POP:
            begin
                if (out_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_next.status = sdtq_pkg::STATUS_OK;
                    if (head_due)
                    begin
                        ctrl.op                  = sdtq_pkg::CELL_SHIFT;
                        count_next               = count_reg - CW'(1);
                        queued_next[c_handle[0]] = 1'b0;
                        rsp_next.expired_handle  = c_handle[0];
                        rsp_next.expired_valid   = 1'b1;
                        // The chain is sorted, so the next cell tells whether more are due.
                        rsp_next.last            = !second_due;
                        if (!second_due)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        rsp_next.expired_handle = '0;
                        rsp_next.expired_valid  = 1'b0;
                        rsp_next.last           = 1'b1;
                        state_next              = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            queued_reg      <= '0;
            rsp_valid_reg   <= 1'b0;
            rsp_reg         <= '0;
            pend_handle_reg <= '0;
            pend_time_reg   <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            queued_reg      <= queued_next;
            rsp_valid_reg   <= rsp_valid_next;
            rsp_reg         <= rsp_next;
            pend_handle_reg <= pend_handle_next;
            pend_time_reg   <= pend_time_next;
        end
    end

endmodule

// ===== hdl/sdtq_checker.sv =====
module sdtq_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input sdtq_pkg::sdtq_req_t req,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input sdtq_pkg::sdtq_rsp_t rsp
);

    // A stalled result beat holds its payload.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result beat changed while stalled");

    // An error status belongs to a single-beat answer without a timer.
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != sdtq_pkg::STATUS_OK) |-> rsp.last && !rsp.expired_valid)
        else $error("error status on a multi-beat or expired result");

    // Only a popped timer may be followed by further beats of the same request.
    a_noexp_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.expired_valid |-> rsp.last)
        else $error("beat without a timer is not the final one");

    // A request is never taken while a non-final pop sequence is still running.
    a_no_accept_mid_tick: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready && !rsp.last |-> !(req_valid && req_ready))
        else $error("request accepted in the middle of a tick");

endmodule

bind sorted_deadline_timer_queue_unit sdtq_checker u_sdtq_checker (.*);
